[design/dvlpi_pkg.sv]
// Shared types and constants for the DVL velocity to position increment block.
// Holds field widths, stream packing offsets, item kinds and register indexes.
// No dependencies.
package dvlpi_pkg;

    localparam int VEL_W     = 16;
    localparam int INC_W     = 20;
    localparam int LIMIT_W   = 15;
    localparam int DT_W      = 16;
    localparam int ERR_W     = 3;
    localparam int KIND_W    = 2;
    localparam int AXES      = 3;

    // signed 16-bit velocity times unsigned 16-bit time
    localparam int PROD_W    = VEL_W + DT_W + 1;
    // velocity Q3.12 times time Q0.16 gives Q3.28; increments are Q3.16
    localparam int FRAC_SHIFT = 12;

    // history of increments, newest first; the incoming increment is tap 0,
    // so only the older taps are stored
    localparam int HIST_TAPS = 4;
    localparam int HIST_DEPTH = HIST_TAPS - 1;

    // weighted sum 1,2,2,1 of 20-bit increments, magnitude below 2^22
    localparam int SUM_W     = INC_W + 3;
    localparam int MAG_W     = SUM_W - 1;

    // divide by 6 as multiply by ceil(2^26 / 6), exact for magnitudes below 2^25
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_SIX = 24'd11184811;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd20480;

    // input tdata: raw_vel_x, raw_vel_y, raw_vel_z, pressure_reading, elapsed_time
    localparam int IN_TDATA_W  = 80;
    localparam int IN_RAW_X_LSB = 0;
    localparam int IN_RAW_Y_LSB = 16;
    localparam int IN_RAW_Z_LSB = 32;
    localparam int IN_PRESS_LSB = 48;
    localparam int IN_DT_LSB    = 64;

    // output tdata: inc_x, inc_y, inc_z, vel_x, vel_y, vel_z, depth, range_error
    localparam int OUT_TDATA_W   = 128;
    localparam int OUT_INC_X_LSB = 0;
    localparam int OUT_INC_Y_LSB = 20;
    localparam int OUT_INC_Z_LSB = 40;
    localparam int OUT_VEL_X_LSB = 60;
    localparam int OUT_VEL_Y_LSB = 76;
    localparam int OUT_VEL_Z_LSB = 92;
    localparam int OUT_DEPTH_LSB = 108;
    localparam int OUT_ERR_LSB   = 124;

    localparam logic signed [VEL_W-1:0] VEL_MOST_NEG = 16'sh8000;
    localparam logic signed [VEL_W-1:0] VEL_MOST_POS = 16'sh7FFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_VELOCITY = 2'd0,
        KIND_PRESSURE = 2'd1,
        KIND_QUERY    = 2'd2
    } kind_t;

    typedef enum logic {
        CFG_MODE  = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_idx_t;

    // control from the top level to the integrator
    typedef struct packed {
        logic push;      // a query leaves the product stage this cycle
        logic weighted;  // integration_mode
    } query_t;

endpackage

[design/dvl_velocity_to_position_increment.sv]
// Top level of the DVL velocity to position increment block.
// Depends on dvlpi_pkg and dvlpi_integrator.
//
//   channel | signals                           | moves
//   --------+-----------------------------------+--------------------------------------
//   in      | s_tvalid s_tready s_tdata s_tuser | one item: kind in tuser, fields in tdata
//   out     | m_tvalid m_tready m_tdata         | one result per item: current state
//   cfg     | cfg_we cfg_index cfg_data         | register write, no handshake
//
// Each item goes from transfer to result through the input register, the product
// register (three 16x17 multiplies) and the result register after the increment stage.
// One item is accepted every cycle while the result side takes transfers.
// A stalled result holds the whole pipeline; s_tready drops only then.
// Reset clears all state, history included, at once; no clearing pass.
module dvl_velocity_to_position_increment
    import dvlpi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // raw_vel_x, raw_vel_y, raw_vel_z, pressure_reading, elapsed_time
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [KIND_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // inc_x, inc_y, inc_z, vel_x, vel_y, vel_z, depth, range_error, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    logic                   advance;

    logic                   mode_reg;
    logic [LIMIT_W-1:0]     limit_reg;

    logic                   in_valid_reg;
    kind_t                  in_kind_reg;
    logic [IN_TDATA_W-1:0]  in_data_reg;

    logic                   mid_valid_reg;
    logic                   mid_query_reg;
    logic signed [PROD_W-1:0] mid_prod_reg  [AXES];
    logic signed [PROD_W-1:0] mid_prod_next [AXES];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic signed [VEL_W-1:0] vel_reg   [AXES];
    logic signed [VEL_W-1:0] vel_next  [AXES];
    logic signed [VEL_W-1:0] depth_reg;
    logic signed [VEL_W-1:0] depth_next;
    logic [ERR_W-1:0]        err_reg;
    logic [ERR_W-1:0]        err_next;

    logic signed [VEL_W:0]   remap [AXES];
    logic [VEL_W:0]          mag   [AXES];
    logic signed [VEL_W-1:0] raw_x;
    logic signed [VEL_W-1:0] raw_y;
    logic signed [VEL_W-1:0] raw_z;
    logic signed [VEL_W-1:0] press;
    logic signed [DT_W:0]    dt_s;

    query_t                  ctl;
    logic signed [INC_W-1:0] inc [AXES];

    // the whole pipeline moves together unless a result waits
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            in_kind_reg <= kind_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    assign raw_x = in_data_reg[IN_RAW_X_LSB +: VEL_W];
    assign raw_y = in_data_reg[IN_RAW_Y_LSB +: VEL_W];
    assign raw_z = in_data_reg[IN_RAW_Z_LSB +: VEL_W];
    assign press = in_data_reg[IN_PRESS_LSB +: VEL_W];
    assign dt_s  = signed'({1'b0, in_data_reg[IN_DT_LSB +: DT_W]});

    // axis remap and range check, one bit wider so that -raw_x cannot wrap
    always_comb
    begin
        remap[0] = (VEL_W+1)'(raw_y);
        remap[1] = -(VEL_W+1)'(raw_x);
        remap[2] = (VEL_W+1)'(raw_z);
        for (int a = 0; a < AXES; a++)
        begin
            mag[a] = remap[a][VEL_W] ? (VEL_W+1)'(-remap[a]) : (VEL_W+1)'(remap[a]);
            err_next[a] = mag[a] > {2'b00, limit_reg};
            vel_next[a] = err_next[a] ? '0 : VEL_W'(remap[a]);
        end
        depth_next = (press == VEL_MOST_NEG) ? VEL_MOST_POS : -press;
        for (int a = 0; a < AXES; a++)
            mid_prod_next[a] = PROD_W'(vel_reg[a]) * PROD_W'(dt_s);
    end

    // state updates as the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
                vel_reg[a] <= '0;
            depth_reg <= '0;
            err_reg   <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            unique case (in_kind_reg)
                KIND_VELOCITY:
                begin
                    for (int a = 0; a < AXES; a++)
                        vel_reg[a] <= vel_next[a];
                    err_reg <= err_next;
                end
                KIND_PRESSURE: depth_reg <= depth_next;
                default:       ;
            endcase
        end
    end

    // product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            mid_query_reg <= 1'b0;
        end
        else if (advance)
        begin
            mid_valid_reg <= in_valid_reg;
            mid_query_reg <= in_valid_reg && (in_kind_reg == KIND_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < AXES; a++)
                mid_prod_reg[a] <= mid_prod_next[a];
        end
    end

    assign ctl.push     = advance && mid_valid_reg && mid_query_reg;
    assign ctl.weighted = mode_reg;

    dvlpi_integrator u_integrator (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .prod  (mid_prod_reg),
        .inc   (inc)
    );

    // result register; the velocity, depth and flag state read here already
    // includes this item, while the next item's update lands on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && mid_valid_reg)
        begin
            out_data_reg <= {1'b0, err_reg, depth_reg,
                             vel_reg[2], vel_reg[1], vel_reg[0],
                             inc[2], inc[1], inc[0]};
        end
    end

endmodule

[design/dvlpi_integrator.sv]
// Increment stage: truncates products to Q3.16, keeps the increment history
// and the last increment, and forms the 1,2,2,1 weighted average.
// Depends on dvlpi_pkg.
module dvlpi_integrator
    import dvlpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  query_t                   ctl,
    input  logic signed [PROD_W-1:0] prod [AXES],
    output logic signed [INC_W-1:0]  inc  [AXES]
);

    logic signed [INC_W-1:0]  hist_reg [HIST_DEPTH][AXES];
    logic signed [INC_W-1:0]  last_reg [AXES];
    logic signed [INC_W-1:0]  inc_now  [AXES];
    logic signed [INC_W-1:0]  avg      [AXES];
    logic signed [PROD_W-1:0] shifted  [AXES];
    logic signed [SUM_W-1:0]  sum      [AXES];
    logic        [MAG_W-1:0]  mag      [AXES];
    logic [MAG_W+RECIP_W-1:0] quot_full [AXES];
    logic        [INC_W-1:0]  quot     [AXES];
    logic                     round_up [AXES];
    logic                     neg      [AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            // arithmetic shift floors; bump negatives with a remainder toward zero
            shifted[a]  = prod[a] >>> FRAC_SHIFT;
            round_up[a] = prod[a][PROD_W-1] && (prod[a][FRAC_SHIFT-1:0] != '0);
            inc_now[a]  = INC_W'(shifted[a] + PROD_W'({1'b0, round_up[a]}));

            sum[a] = SUM_W'(inc_now[a])
                   + (SUM_W'(hist_reg[0][a]) <<< 1)
                   + (SUM_W'(hist_reg[1][a]) <<< 1)
                   + SUM_W'(hist_reg[2][a]);
            neg[a] = sum[a][SUM_W-1];
            mag[a] = neg[a] ? MAG_W'(-sum[a]) : MAG_W'(sum[a]);
            quot_full[a] = (MAG_W+RECIP_W)'(mag[a]) * (MAG_W+RECIP_W)'(RECIP_SIX);
            quot[a] = INC_W'(quot_full[a] >> RECIP_SHIFT);
            avg[a]  = neg[a] ? -signed'(quot[a]) : signed'(quot[a]);

            if (ctl.push)
                inc[a] = ctl.weighted ? avg[a] : inc_now[a];
            else
                inc[a] = last_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                last_reg[a] <= '0;
                for (int t = 0; t < HIST_DEPTH; t++)
                    hist_reg[t][a] <= '0;
            end
        end
        else if (ctl.push)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                last_reg[a] <= inc[a];
                // plain mode leaves the history alone
                if (ctl.weighted)
                begin
                    hist_reg[0][a] <= inc_now[a];
                    for (int t = 1; t < HIST_DEPTH; t++)
                        hist_reg[t][a] <= hist_reg[t-1][a];
                end
            end
        end
    end

endmodule

[design/dvlpi_checker.sv]
// Port-level checks for the DVL velocity to position increment block,
// attached to the top level by the bind at the end. Depends on dvlpi_pkg.
module dvlpi_checker
    import dvlpi_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side backs up only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // with the output draining, a transfer in shows up as a result once past the input and product registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // a flagged axis reads as zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (!m_tdata[OUT_ERR_LSB]   || m_tdata[OUT_VEL_X_LSB +: VEL_W] == '0) &&
            (!m_tdata[OUT_ERR_LSB+1] || m_tdata[OUT_VEL_Y_LSB +: VEL_W] == '0) &&
            (!m_tdata[OUT_ERR_LSB+2] || m_tdata[OUT_VEL_Z_LSB +: VEL_W] == '0))
        else $error("flagged axis has nonzero velocity");

    // depth saturates, never the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DEPTH_LSB +: VEL_W] != VEL_MOST_NEG)
        else $error("depth not saturated");

endmodule

bind dvl_velocity_to_position_increment dvlpi_checker u_dvlpi_checker (.*);
